@@ rtl/two_wire_bus_master_unit_macros.svh @@
// Assertion macros for the two-wire bus master.
`ifndef TWO_WIRE_BUS_MASTER_UNIT_MACROS_SVH
`define TWO_WIRE_BUS_MASTER_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define TWB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TWB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ rtl/twb_pkg.sv @@
// Package: types, codes and constants of the two-wire bus master.
`timescale 1ns / 1ps
package twb_pkg;
   localparam int CountWidth = 8;

   typedef enum logic [2:0] {
      KIND_TICK    = 3'd0,
      KIND_START   = 3'd1,
      KIND_STOP    = 3'd2,
      KIND_WRITE   = 3'd3,
      KIND_READ    = 3'd4,
      KIND_SSTART  = 3'd5,
      KIND_SCMD    = 3'd6,
      KIND_SREAD16 = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      REG_SHORT = 2'd0,
      REG_MID   = 2'd1,
      REG_LONG  = 2'd2
   } reg_index_type;

   // Classified transaction passed from front to back.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic        ack_enable;
      logic        sda_in;
   } item_type;

   // One result transaction.
   typedef struct packed {
      logic        scl_level;
      logic        sda_released;
      logic        busy_res;
      logic        done_res;
      logic        ack_seen;
      logic [15:0] read_value;
      logic        ignored;
   } result_type;

   // Tick count loaded into the delay counter: zero becomes one.
   function automatic logic [CountWidth-1:0] load_ticks(input logic [7:0] v);
      logic [CountWidth-1:0] r;
      r = (v == 8'd0) ? CountWidth'(1) : CountWidth'(v);
      return r;
   endfunction
endpackage

@@ rtl/twb_front.sv @@
// Front part: input transaction register that feeds the sequencer queue.
`timescale 1ns / 1ps
module twb_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [2:0]         req_tuser,
   input  logic [15:0]        req_tdata,
   output logic               q_valid,
   input  logic               q_ready,
   output twb_pkg::item_type  q_item
);
   logic              full_ff, full_in;
   twb_pkg::item_type item_ff, item_in;

   assign req_tready = !full_ff || q_ready;
   assign q_valid    = full_ff;
   assign q_item     = item_ff;

   // One-entry queue slot that can refill in the same cycle as it drains.
   always_comb begin
      full_in = full_ff;
      item_in = item_ff;
      if (req_tvalid && req_tready) begin
         full_in = 1'b1;
         item_in.kind       = twb_pkg::kind_type'(req_tuser);
         item_in.data_byte  = req_tdata[7:0];
         item_in.ack_enable = req_tdata[8];
         item_in.sda_in     = req_tdata[9];
      end else if (q_ready) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
      item_ff <= item_in;
   end
endmodule

@@ rtl/twb_back.sv @@
// Back part: bus sequencer advanced by each transaction (delay count or phase), with output register.
`timescale 1ns / 1ps
module twb_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  twb_pkg::item_type   q_item,
   input  logic [7:0]          short_ticks,
   input  logic [7:0]          mid_ticks,
   input  logic [7:0]          long_ticks,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output twb_pkg::result_type rsp_res
);
   localparam int CW = twb_pkg::CountWidth;

   logic [2:0]  op_ff, op_in;
   logic [4:0]  ph_ff, ph_in;
   logic [4:0]  bc_ff, bc_in;
   logic [CW-1:0] dc_ff, dc_in;
   logic [15:0] sw_ff, sw_in;
   logic        scl_ff, scl_in, sda_ff, sda_in_r, ack_ff, ack_in;
   logic        ov_ff, ov_in;
   twb_pkg::result_type res_ff, res_in;

   logic [CW-1:0] s_t, m_t, l_t, one_t, zero_t;
   logic fire, fin, done;
   logic [15:0] sh8;
   logic sda;
   logic [2:0] k;

   assign s_t = twb_pkg::load_ticks(short_ticks);
   assign m_t = twb_pkg::load_ticks(mid_ticks);
   assign l_t = twb_pkg::load_ticks(long_ticks);
   assign one_t = CW'(1);
   assign zero_t = '0;
   assign q_ready = !ov_ff || rsp_tready;
   assign rsp_tvalid = ov_ff;
   assign rsp_res = res_ff;
   assign sda = q_item.sda_in;
   assign k = q_item.kind;
   assign sh8 = {8'd0, sw_ff[6:0], 1'b0};

   // Next state of the sequencer for one transaction.
   always_comb begin
      op_in = op_ff; ph_in = ph_ff; bc_in = bc_ff; dc_in = dc_ff; sw_in = sw_ff;
      scl_in = scl_ff; sda_in_r = sda_ff; ack_in = ack_ff;
      fire = 1'b0; fin = 1'b0; done = 1'b0;
      res_in = '0;
      if (k != twb_pkg::KIND_TICK) begin
         if (op_ff != twb_pkg::KIND_TICK) begin
            res_in.ignored = 1'b1;
         end else begin
            op_in = k; bc_in = '0; ph_in = '0;
            case (k)
               twb_pkg::KIND_START: begin sda_in_r = 1'b1; dc_in = l_t; end
               twb_pkg::KIND_STOP: begin sda_in_r = 1'b0; dc_in = l_t; end
               twb_pkg::KIND_WRITE: begin
                  sw_in = {8'd0, q_item.data_byte}; sda_in_r = q_item.data_byte[7];
                  dc_in = s_t;
               end
               twb_pkg::KIND_READ: begin
                  ack_in = q_item.ack_enable; sw_in = '0; sda_in_r = 1'b1; dc_in = s_t;
               end
               twb_pkg::KIND_SSTART: begin sda_in_r = 1'b1; dc_in = one_t; end
               twb_pkg::KIND_SCMD: begin
                  sw_in = {8'd0, q_item.data_byte}; scl_in = 1'b0;
                  sda_in_r = q_item.data_byte[7]; dc_in = s_t;
               end
               default: begin
                  sw_in = '0; scl_in = 1'b0; sda_in_r = 1'b1; dc_in = s_t;
               end
            endcase
         end
      end else if (op_ff != twb_pkg::KIND_TICK) begin
         if (op_ff == twb_pkg::KIND_SCMD && (ph_ff == 5'd2 || ph_ff == 5'd5)) fire = !sda;
         else if (op_ff == twb_pkg::KIND_SCMD && ph_ff == 5'd4) fire = sda;
         else if (dc_ff > one_t) dc_in = dc_ff - one_t;
         else fire = 1'b1;
         if (fire) begin
            case (op_ff)
               twb_pkg::KIND_START, twb_pkg::KIND_STOP: begin
                  if (ph_ff == 5'd0) begin scl_in = 1'b1; ph_in = 5'd1; dc_in = l_t; end
                  else if (ph_ff == 5'd1) begin
                     sda_in_r = (op_ff == twb_pkg::KIND_STOP); ph_in = 5'd2; dc_in = l_t;
                  end else begin
                     if (op_ff == twb_pkg::KIND_START) scl_in = 1'b0;
                     fin = 1'b1;
                  end
               end
               twb_pkg::KIND_WRITE: begin
                  unique case (ph_ff)
                     5'd0: begin scl_in = 1'b1; ph_in = 5'd1; dc_in = m_t; end
                     5'd1: begin scl_in = 1'b0; ph_in = 5'd2; dc_in = s_t; end
                     5'd2: begin
                        sw_in = sh8;
                        if (bc_ff < 5'd7) begin
                           bc_in = bc_ff + 5'd1; sda_in_r = sh8[7];
                           ph_in = 5'd0; dc_in = s_t;
                        end else begin sda_in_r = 1'b1; ph_in = 5'd3; dc_in = s_t; end
                     end
                     5'd3: begin scl_in = 1'b1; ph_in = 5'd4; dc_in = m_t; end
                     5'd4: begin
                        ack_in = !sda; scl_in = 1'b0; ph_in = 5'd5; dc_in = l_t;
                     end
                     default: fin = 1'b1;
                  endcase
               end
               twb_pkg::KIND_READ: begin
                  unique case (ph_ff)
                     5'd0: begin ph_in = 5'd1; dc_in = s_t; end
                     5'd1: begin scl_in = 1'b1; ph_in = 5'd2; dc_in = m_t; end
                     5'd2: begin
                        sw_in = {8'd0, sw_ff[6:0], sda};
                        scl_in = 1'b0; ph_in = 5'd3; dc_in = s_t;
                     end
                     5'd3: begin
                        if (bc_ff < 5'd7) begin
                           bc_in = bc_ff + 5'd1; ph_in = 5'd1; dc_in = s_t;
                        end else begin sda_in_r = !ack_ff; ph_in = 5'd4; dc_in = s_t; end
                     end
                     5'd4: begin scl_in = 1'b1; ph_in = 5'd5; dc_in = m_t; end
                     5'd5: begin scl_in = 1'b0; ph_in = 5'd6; dc_in = s_t; end
                     5'd6: begin sda_in_r = 1'b1; ph_in = 5'd7; dc_in = l_t; end
                     default: fin = 1'b1;
                  endcase
               end
               twb_pkg::KIND_SSTART: begin
                  dc_in = one_t; ph_in = ph_ff + 5'd1;
                  unique case (ph_ff)
                     5'd0: scl_in = 1'b1;
                     5'd1: sda_in_r = 1'b0;
                     5'd2: scl_in = 1'b0;
                     5'd3: scl_in = 1'b1;
                     5'd4: sda_in_r = 1'b1;
                     default: begin scl_in = 1'b0; fin = 1'b1; end
                  endcase
               end
               twb_pkg::KIND_SCMD: begin
                  unique case (ph_ff)
                     5'd0: begin scl_in = 1'b1; ph_in = 5'd1; dc_in = m_t; end
                     5'd1: begin
                        sw_in = sh8; scl_in = 1'b0;
                        if (bc_ff < 5'd7) begin
                           bc_in = bc_ff + 5'd1; sda_in_r = sh8[7];
                           ph_in = 5'd0; dc_in = s_t;
                        end else begin sda_in_r = 1'b1; ph_in = 5'd2; dc_in = zero_t; end
                     end
                     5'd2: begin scl_in = 1'b1; ph_in = 5'd3; dc_in = one_t; end
                     5'd3: begin scl_in = 1'b0; ph_in = 5'd4; dc_in = zero_t; end
                     5'd4: begin ph_in = 5'd5; dc_in = zero_t; end
                     default: fin = 1'b1;
                  endcase
               end
               default: begin
                  unique case (ph_ff)
                     5'd0: begin scl_in = 1'b1; ph_in = 5'd1; dc_in = m_t; end
                     5'd1: begin
                        scl_in = 1'b0;
                        if (bc_ff == 5'd8) begin
                           sda_in_r = 1'b1; bc_in = 5'd9; ph_in = 5'd0; dc_in = s_t;
                        end else begin
                           sw_in = {sw_ff[14:0], sda}; ph_in = 5'd2; dc_in = s_t;
                        end
                     end
                     5'd2: begin
                        if (bc_ff < 5'd16) begin
                           bc_in = bc_ff + 5'd1;
                           if (bc_ff == 5'd7) sda_in_r = 1'b0;
                           ph_in = 5'd0; dc_in = s_t;
                        end else fin = 1'b1;
                     end
                     default: fin = 1'b1;
                  endcase
               end
            endcase
         end
         if (fin) begin
            done = 1'b1;
            if (op_ff == twb_pkg::KIND_WRITE) res_in.ack_seen = ack_in;
            if (op_ff == twb_pkg::KIND_READ || op_ff == twb_pkg::KIND_SREAD16)
               res_in.read_value = sw_in;
            op_in = twb_pkg::KIND_TICK; ph_in = '0; dc_in = '0;
         end
      end
      res_in.scl_level = scl_in;
      res_in.sda_released = sda_in_r;
      res_in.busy_res = (op_in != twb_pkg::KIND_TICK);
      res_in.done_res = done;
   end

   assign ov_in = (q_valid && q_ready) ? 1'b1 : (rsp_tready ? 1'b0 : ov_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= '0; ph_ff <= '0; bc_ff <= '0; dc_ff <= '0; sw_ff <= '0;
         scl_ff <= 1'b1; sda_ff <= 1'b1; ack_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in;
         if (q_valid && q_ready) begin
            op_ff <= op_in; ph_ff <= ph_in; bc_ff <= bc_in; dc_ff <= dc_in;
            sw_ff <= sw_in; scl_ff <= scl_in; sda_ff <= sda_in_r; ack_ff <= ack_in;
         end
      end
      if (q_valid && q_ready) res_ff <= res_in;
   end
endmodule

@@ rtl/twb_csr.sv @@
// Tick-count configuration registers.
`timescale 1ns / 1ps
module twb_csr (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output logic [7:0] short_ticks,
   output logic [7:0] mid_ticks,
   output logic [7:0] long_ticks
);
   logic [7:0] s_ff, m_ff, l_ff;
   assign short_ticks = s_ff;
   assign mid_ticks = m_ff;
   assign long_ticks = l_ff;

   // Register write decode.
   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff <= 8'd2; m_ff <= 8'd5; l_ff <= 8'd10;
      end else if (csr_we) begin
         unique case (csr_index)
            twb_pkg::REG_SHORT: s_ff <= csr_wdata;
            twb_pkg::REG_MID:   m_ff <= csr_wdata;
            twb_pkg::REG_LONG:  l_ff <= csr_wdata;
            default: ;
         endcase
      end
   end
endmodule

@@ rtl/two_wire_bus_master_unit.sv @@
// Top level of the two-wire bus master.
//  channel | direction | tdata                                  | tuser
//  req     | in        | data_byte, ack_enable, sda_in          | kind
//  rsp     | out       | scl_level, sda_released, busy_res,     | -
//          |           | done_res, ack_seen, read_value, ignored|
//  csr     | in        | write enable, index 0..2, 8-bit value  | -
// One transaction per clock unless stalled; each tick steps a delay or phase.
// Results pass through the front slot, then the sequencer result register.
// Synchronous reset clears state; ticks reload to 2, 5 and 10.
// Either side may stall; the slot and output register hold their contents.
`timescale 1ns / 1ps
`include "two_wire_bus_master_unit_macros.svh"
module two_wire_bus_master_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // data_byte[7:0], ack_enable[8], sda_in[9]
   input  logic [2:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // scl_level, sda_released, busy_res, done_res,
                                    // ack_seen, read_value[20:5], ignored[21]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   logic q_valid, q_ready;
   twb_pkg::item_type q_item;
   twb_pkg::result_type res;
   logic [7:0] s_t, m_t, l_t;

   twb_csr u_csr (.clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .short_ticks(s_t), .mid_ticks(m_t), .long_ticks(l_t));
   twb_front u_front (.clock, .reset, .req_tvalid, .req_tready, .req_tuser,
      .req_tdata, .q_valid, .q_ready, .q_item);
   twb_back u_back (.clock, .reset, .q_valid, .q_ready, .q_item,
      .short_ticks(s_t), .mid_ticks(m_t), .long_ticks(l_t),
      .rsp_tvalid, .rsp_tready, .rsp_res(res));

   assign rsp_tdata = {2'b00, res.ignored, res.read_value, res.ack_seen,
      res.done_res, res.busy_res, res.sda_released, res.scl_level};

   `TWB_ASSERT_IMP(a_done_not_busy, clock, reset, rsp_tvalid && rsp_tdata[3], !rsp_tdata[2])
   `TWB_ASSERT_IMP(a_ign_not_done, clock, reset, rsp_tvalid && rsp_tdata[21], !rsp_tdata[3])
   `TWB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
endmodule
